### hw/rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam logic       MODE_PUT   = 1'b0;
  localparam logic       MODE_READ  = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;

  localparam logic [15:0] BLANK_CELL = 16'h0700;

  localparam logic [3:0] FG_RESET = 4'h7;
  localparam logic [3:0] BG_RESET = 4'h0;

  // configuration register indexes
  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  // cursor operations
  typedef logic [1:0] cur_op_t;
  localparam cur_op_t CUR_HOLD    = 2'd0;
  localparam cur_op_t CUR_RETURN  = 2'd1;
  localparam cur_op_t CUR_NEWLINE = 2'd2;
  localparam cur_op_t CUR_ADVANCE = 2'd3;

  typedef struct packed {
    logic       col_last;
    logic       row_last;
  } cur_status_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } out_t;

  typedef struct packed {
    logic       index;
    logic [3:0] value;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/tcw_ram.sv
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/tcw_cursor.sv
`default_nettype none
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int AW = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tcw_pkg::cur_op_t     op,
  output tcw_pkg::cur_status_t      status,
  output logic         [AW-1:0]     pos
);
  import tcw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] pos_next;
  logic [AW-1:0] line_start;
  logic [AW-1:0] next_line_start;

  assign status.col_last = (col == CW'(COLUMNS - 1));
  assign status.row_last = (row == RW'(ROWS - 1));

  assign line_start = pos - AW'(col);
  // on the last row the cursor stays on that row and the store scrolls instead
  assign next_line_start = status.row_last ? line_start : line_start + AW'(COLUMNS);

  always_comb begin
    col_next = col;
    row_next = row;
    pos_next = pos;
    case (op)
      CUR_RETURN: begin
        col_next = '0;
        pos_next = line_start;
      end
      CUR_NEWLINE: begin
        col_next = '0;
        row_next = status.row_last ? row : row + RW'(1);
        pos_next = next_line_start;
      end
      CUR_ADVANCE: begin
        if (status.col_last) begin
          col_next = '0;
          row_next = status.row_last ? row : row + RW'(1);
          pos_next = next_line_start;
        end else begin
          col_next = col + CW'(1);
          pos_next = pos + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pos <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      pos <= pos_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/text_console_writer_core.sv
// text console writer: a ROWS x COLUMNS store of 16-bit character cells
// {bg, fg, char} with a cursor.
// input channel (in_valid/in_ready/in_data): mode put writes a character,
// handles newline and carriage return; mode read fetches one stored cell.
// output channel (out_valid/out_ready/out_data): one result per item with
// the cursor position after the item and the cell read (zero for puts).
// config channel (cfg_valid/cfg_ready/cfg_data): index 0 sets the foreground
// nibble, index 1 the background nibble; always ready, write it while idle.
// steps with the receiver ready: a put passes the execute and response steps,
// a read in range adds a wait step for the registered read of the cell memory,
// and a read past the store goes from execute straight to the response step.
// a newline or wrap on the last row scrolls: one read and one write of the
// memory per copied cell, then the bottom row is blanked before the result.
// after reset a clearing pass writes the blank cell 0x0700 into every entry;
// no item is taken during the pass.
// the result sits in an output register; while the receiver stalls the
// block still takes one more item, runs it and then holds it in the response
// step, taking nothing further until the output register frees.
`default_nettype none
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tcw_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcw_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire tcw_pkg::cfg_t cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] cnt;
  logic          wr_pend;
  logic [AW-1:0] wr_addr_q;
  in_t           item;
  logic [15:0]   cell_q;
  logic [3:0]    fg;
  logic [3:0]    bg;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          is_char;
  logic          in_range;
  logic [31:0]   idx_full;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  cur_op_t       cur_op;
  cur_status_t   cur_status;
  logic [AW-1:0] cur_pos;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .op     (cur_op),
    .status (cur_status),
    .pos    (cur_pos)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_RESP) && out_free;
  assign in_ready  = (state == S_IDLE) || out_load;
  assign in_fire   = in_valid && in_ready;

  assign is_char  = (item.char_code != CH_NEWLINE) && (item.char_code != CH_RETURN);
  assign idx_full = 32'(item.cell_index);
  assign in_range = idx_full < 32'(CELLS);

  always_comb begin
    cur_op = CUR_HOLD;
    if (state == S_EXEC && item.mode == MODE_PUT) begin
      if (item.char_code == CH_NEWLINE) begin
        cur_op = CUR_NEWLINE;
      end else if (item.char_code == CH_RETURN) begin
        cur_op = CUR_RETURN;
      end else begin
        cur_op = CUR_ADVANCE;
      end
    end
  end

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = BLANK_CELL;
    ram_raddr = cnt;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        ram_raddr = idx_full[AW-1:0];
        if (item.mode == MODE_PUT && is_char) begin
          ram_we    = 1'b1;
          ram_waddr = cur_pos;
          ram_wdata = {bg, fg, item.char_code};
        end
      end
      S_SCROLL: begin
        // read one row down, write it back in the next cycle
        ram_raddr = cnt + AW'(COLUMNS);
        ram_we    = wr_pend;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (item.mode == MODE_READ) begin
            state <= in_range ? S_RDWAIT : S_RESP;
          end else if (cur_status.row_last &&
                       ((item.char_code == CH_NEWLINE) ||
                        (is_char && cur_status.col_last))) begin
            state   <= S_SCROLL;
            cnt     <= '0;
            wr_pend <= 1'b0;
          end else begin
            state <= S_RESP;
          end
        end
        S_RDWAIT: begin
          state <= S_RESP;
        end
        S_SCROLL: begin
          if (cnt == AW'(CELLS - COLUMNS)) begin
            // last copy write drains now; cnt already points at the bottom row
            wr_pend <= 1'b0;
            state   <= S_FILL;
          end else begin
            wr_addr_q <= cnt;
            wr_pend   <= 1'b1;
            cnt       <= cnt + AW'(1);
          end
        end
        S_FILL: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_RESP;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_RESP: begin
          if (out_load) begin
            state <= in_fire ? S_EXEC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
    if (state == S_EXEC) begin
      cell_q <= '0;
    end else if (state == S_RDWAIT) begin
      cell_q <= ram_rdata;
    end
    if (out_load) begin
      out_data.cursor_position <= 11'(cur_pos);
      out_data.cell_value      <= cell_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_data.index)
        CFG_FOREGROUND: fg <= cfg_data.value;
        CFG_BACKGROUND: bg <= cfg_data.value;
        default: ;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE || state == S_RESP))
    else $error("item taken while the sequencer is busy");

  a_cursor_in_store: assert property (@(posedge clk) disable iff (rst)
    32'(cur_pos) < 32'(CELLS))
    else $error("cursor outside the text store");

  a_scroll_write_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && ram_we) |-> 32'(wr_addr_q) < 32'(CELLS - COLUMNS))
    else $error("scroll copy wrote into the bottom row");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESP)
    else $error("result appeared outside the response step");

endmodule
`default_nettype wire
